// File: design/qpm_pkg.sv
// Shared types and constants for the quadrature position mover.
// Used by qpm_ctrl, qpm_datapath and quadrature_position_mover; no dependencies.
package qpm_pkg;

    // Default and field widths.
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int POS_OUT_W   = 32;
    localparam int TARGET_W    = 32;
    localparam int SPEED_W     = 8;
    localparam int ROT_W       = 16;
    localparam int GEAR_W      = 10;
    localparam int CPR_W       = 12;
    localparam int PROD1_W     = ROT_W + GEAR_W;
    localparam int PROD2_W     = PROD1_W + CPR_W;
    localparam int ROT_FRAC_W  = 8;
    localparam int DELTA_W     = PROD2_W - ROT_FRAC_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 48;

    // Register reset values.
    localparam logic [GEAR_W-1:0]  GEAR_RATIO_RST     = GEAR_W'(1);
    localparam logic [CPR_W-1:0]   COUNTS_PER_REV_RST = CPR_W'(48);
    localparam logic [SPEED_W-1:0] HOME_SPEED_RST     = SPEED_W'(80);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEAR_RATIO     = 2'd0,
        CFG_COUNTS_PER_REV = 2'd1,
        CFG_HOME_SPEED     = 2'd2
    } cfg_idx_t;

    // Operation codes carried in tuser.
    typedef enum logic [2:0] {
        OP_SAMPLE     = 3'd0,
        OP_GOTO       = 3'd1,
        OP_MOVE_ROT   = 3'd2,
        OP_GO_HOME    = 3'd3,
        OP_RESET_HOME = 3'd4
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MUL   = 2'd1,
        ST_APPLY = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;       // execute a non-rotation operation and load the result
        logic rot_load;   // capture rotation operands, first multiply
        logic rot_mul;    // second multiply
        logic rot_apply;  // start the rotation move and load the result
    } dp_cmd_t;

endpackage

// File: design/quadrature_position_mover.sv
// Quadrature x4 position counter with move control for one motor channel.
// Each result is registered; a rotation move loads its result in the APPLY state, after MUL.
// Throughput: one item per cycle while idle; a rotation move holds off the input while
// in the MUL and APPLY states, and a result left waiting holds off the next input.
// Reset: synchronous, active low; clears position and move state, loads
// register defaults. Depends on qpm_pkg, qpm_ctrl and qpm_datapath.
module quadrature_position_mover #(
    parameter int POSITION_BITS = qpm_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [qpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: enc_a[0], enc_b[1], speed[9:2], move_reverse[10],
    // target_count[42:11], rotations_q8[58:43], zero[63:59]
    input  logic [qpm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]                      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: position[31:0], motor_on[32], motor_reverse[33],
    // motor_speed[41:34], move_done[42], zero[47:43]
    output logic [qpm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    qpm_pkg::dp_cmd_t              cmd;
    logic [qpm_pkg::POS_OUT_W-1:0] position;
    logic                          motor_on;
    logic                          motor_reverse;
    logic [qpm_pkg::SPEED_W-1:0]   motor_speed;
    logic                          move_done;

    qpm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    qpm_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .operation     (s_axis_tuser),
        .enc_a         (s_axis_tdata[0]),
        .enc_b         (s_axis_tdata[1]),
        .speed         (s_axis_tdata[9:2]),
        .move_reverse  (s_axis_tdata[10]),
        .target_count  (s_axis_tdata[42:11]),
        .rotations_q8  (s_axis_tdata[58:43]),
        .position      (position),
        .motor_on      (motor_on),
        .motor_reverse (motor_reverse),
        .motor_speed   (motor_speed),
        .move_done     (move_done)
    );

    // Pack the result fields, highest field first.
    assign m_axis_tdata = {5'd0, move_done, motor_speed, motor_reverse, motor_on, position};

endmodule

// File: design/qpm_ctrl.sv
// Controller state machine for the quadrature position mover.
// Depends on qpm_pkg; drives the stream handshakes and datapath commands.
module qpm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [2:0]      s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output qpm_pkg::dp_cmd_t cmd
);

    qpm_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            is_rot;

    // Input is taken only when idle and the result register is free or draining.
    assign s_axis_tready = (state_reg == qpm_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_rot        = (s_axis_tuser == qpm_pkg::OP_MOVE_ROT);
    assign m_axis_tvalid = out_valid_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qpm_pkg::ST_IDLE: begin
                if (accept && is_rot) begin
                    state_next = qpm_pkg::ST_MUL;
                end
            end
            qpm_pkg::ST_MUL: begin
                state_next = qpm_pkg::ST_APPLY;
            end
            qpm_pkg::ST_APPLY: begin
                state_next = qpm_pkg::ST_IDLE;
            end
            default: begin
                state_next = qpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            qpm_pkg::ST_IDLE: begin
                cmd.step     = accept && !is_rot;
                cmd.rot_load = accept && is_rot;
            end
            qpm_pkg::ST_MUL: begin
                cmd.rot_mul = 1'b1;
            end
            qpm_pkg::ST_APPLY: begin
                cmd.rot_apply = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Result valid: set on a result load, cleared when the transfer completes.
    always_comb begin
        if (cmd.step || cmd.rot_apply) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qpm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/qpm_datapath.sv
// Datapath for the quadrature position mover: position counter, move state,
// rotation multiplier and result register. Depends on qpm_pkg.
module qpm_datapath #(
    parameter int POSITION_BITS = qpm_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [qpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  qpm_pkg::dp_cmd_t                cmd,
    input  logic [2:0]                      operation,
    input  logic                            enc_a,
    input  logic                            enc_b,
    input  logic [qpm_pkg::SPEED_W-1:0]     speed,
    input  logic                            move_reverse,
    input  logic [qpm_pkg::TARGET_W-1:0]    target_count,
    input  logic [qpm_pkg::ROT_W-1:0]       rotations_q8,
    output logic [qpm_pkg::POS_OUT_W-1:0]   position,
    output logic                            motor_on,
    output logic                            motor_reverse,
    output logic [qpm_pkg::SPEED_W-1:0]     motor_speed,
    output logic                            move_done
);

    localparam int PW = POSITION_BITS;

    // Configuration registers.
    logic [qpm_pkg::GEAR_W-1:0]  gear_ratio_reg;
    logic [qpm_pkg::CPR_W-1:0]   counts_per_rev_reg;
    logic [qpm_pkg::SPEED_W-1:0] home_speed_reg;

    // Counter and move state.
    logic [PW-1:0]               count_reg, count_next;
    logic                        last_a_reg, last_a_next;
    logic                        last_b_reg, last_b_next;
    logic                        primed_reg, primed_next;
    logic [PW-1:0]               goal_reg, goal_next;
    logic                        moving_reg, moving_next;
    logic                        drive_rev_reg, drive_rev_next;
    logic [qpm_pkg::SPEED_W-1:0] drive_speed_reg, drive_speed_next;

    // Rotation multiplier stages and captured operands.
    logic [qpm_pkg::PROD1_W-1:0] prod1_reg;
    logic [qpm_pkg::PROD2_W-1:0] prod2_reg;
    logic                        rot_rev_reg;
    logic [qpm_pkg::SPEED_W-1:0] rot_speed_reg;
    logic [qpm_pkg::DELTA_W-1:0] delta;
    logic [PW-1:0]               delta_pos;

    // Result register.
    logic [qpm_pkg::POS_OUT_W-1:0] position_reg;
    logic                          motor_on_reg;
    logic                          motor_rev_reg;
    logic [qpm_pkg::SPEED_W-1:0]   motor_speed_reg;
    logic                          move_done_reg;

    logic check;
    logic reached;
    logic done;

    assign delta     = prod2_reg[qpm_pkg::PROD2_W-1:qpm_pkg::ROT_FRAC_W];
    assign delta_pos = PW'(delta);

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gear_ratio_reg     <= qpm_pkg::GEAR_RATIO_RST;
            counts_per_rev_reg <= qpm_pkg::COUNTS_PER_REV_RST;
            home_speed_reg     <= qpm_pkg::HOME_SPEED_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                qpm_pkg::CFG_GEAR_RATIO: begin
                    gear_ratio_reg <= cfg_data[qpm_pkg::GEAR_W-1:0];
                end
                qpm_pkg::CFG_COUNTS_PER_REV: begin
                    counts_per_rev_reg <= cfg_data[qpm_pkg::CPR_W-1:0];
                end
                qpm_pkg::CFG_HOME_SPEED: begin
                    home_speed_reg <= cfg_data[qpm_pkg::SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Two registered multiply stages for the rotation distance.
    always_ff @(posedge aclk) begin
        if (cmd.rot_load) begin
            prod1_reg     <= qpm_pkg::PROD1_W'(rotations_q8) * qpm_pkg::PROD1_W'(gear_ratio_reg);
            rot_rev_reg   <= move_reverse;
            rot_speed_reg <= speed;
        end
        if (cmd.rot_mul) begin
            prod2_reg <= qpm_pkg::PROD2_W'(prod1_reg) * qpm_pkg::PROD2_W'(counts_per_rev_reg);
        end
    end

    // Operation execution followed by the goal test.
    always_comb begin
        count_next       = count_reg;
        last_a_next      = last_a_reg;
        last_b_next      = last_b_reg;
        primed_next      = primed_reg;
        goal_next        = goal_reg;
        moving_next      = moving_reg;
        drive_rev_next   = drive_rev_reg;
        drive_speed_next = drive_speed_reg;
        check            = 1'b0;

        if (cmd.step) begin
            case (operation)
                qpm_pkg::OP_SAMPLE: begin
                    if (!primed_reg) begin
                        last_a_next = enc_a;
                        last_b_next = enc_b;
                        primed_next = 1'b1;
                    end else if (enc_a != last_a_reg) begin
                        last_a_next = enc_a;
                        count_next  = (enc_a != enc_b) ? count_reg + PW'(1)
                                                       : count_reg - PW'(1);
                        check       = 1'b1;
                    end else if (enc_b != last_b_reg) begin
                        last_b_next = enc_b;
                        count_next  = (enc_a == enc_b) ? count_reg + PW'(1)
                                                       : count_reg - PW'(1);
                        check       = 1'b1;
                    end
                end
                qpm_pkg::OP_GOTO: begin
                    goal_next        = PW'($signed(target_count));
                    drive_rev_next   = move_reverse;
                    drive_speed_next = speed;
                    moving_next      = 1'b1;
                    check            = 1'b1;
                end
                qpm_pkg::OP_GO_HOME: begin
                    goal_next        = '0;
                    drive_rev_next   = !count_reg[PW-1] && (count_reg != '0);
                    drive_speed_next = home_speed_reg;
                    moving_next      = 1'b1;
                    check            = 1'b1;
                end
                qpm_pkg::OP_RESET_HOME: begin
                    count_next = '0;
                    check      = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (cmd.rot_apply) begin
            goal_next        = rot_rev_reg ? count_reg - delta_pos : count_reg + delta_pos;
            drive_rev_next   = rot_rev_reg;
            drive_speed_next = rot_speed_reg;
            moving_next      = 1'b1;
            check            = 1'b1;
        end

        // A forward move ends at or past the goal, a reverse move at or below it.
        if (drive_rev_next) begin
            reached = $signed(goal_next) >= $signed(count_next);
        end else begin
            reached = $signed(count_next) >= $signed(goal_next);
        end
        done = check && moving_next && reached;
        if (done) begin
            moving_next      = 1'b0;
            drive_rev_next   = 1'b0;
            drive_speed_next = '0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            last_a_reg      <= 1'b0;
            last_b_reg      <= 1'b0;
            primed_reg      <= 1'b0;
            goal_reg        <= '0;
            moving_reg      <= 1'b0;
            drive_rev_reg   <= 1'b0;
            drive_speed_reg <= '0;
        end else begin
            count_reg       <= count_next;
            last_a_reg      <= last_a_next;
            last_b_reg      <= last_b_next;
            primed_reg      <= primed_next;
            goal_reg        <= goal_next;
            moving_reg      <= moving_next;
            drive_rev_reg   <= drive_rev_next;
            drive_speed_reg <= drive_speed_next;
        end
    end

    // Result register, loaded when an item finishes.
    always_ff @(posedge aclk) begin
        if (cmd.step || cmd.rot_apply) begin
            position_reg    <= qpm_pkg::POS_OUT_W'($signed(count_next));
            motor_on_reg    <= moving_next;
            motor_rev_reg   <= moving_next && drive_rev_next;
            motor_speed_reg <= moving_next ? drive_speed_next : '0;
            move_done_reg   <= done;
        end
    end

    assign position      = position_reg;
    assign motor_on      = motor_on_reg;
    assign motor_reverse = motor_rev_reg;
    assign motor_speed   = motor_speed_reg;
    assign move_done     = move_done_reg;

endmodule

// File: tb/sv/quadrature_position_mover_tb.sv
// Self-checking testbench for quadrature_position_mover: a directed table followed by
// random encoder walks and move commands under several register settings.
// Depends on qpm_pkg and the quadrature_position_mover RTL.
module quadrature_position_mover_tb;

    localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES  = 400;   // long output stall
    localparam int DRAIN_CYCLES = 6;     // settle time after the last result
    localparam int RANDOM_ITEMS = 260;   // per register setting
    localparam int SCRIPT_ROWS  = 27;
    localparam int PHASES       = 5;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [2:0] OP_LAST_SPARE  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic        enc_a;
        logic        enc_b;
        logic [7:0]  speed;
        logic        rev;
        logic [31:0] target;
        logic [15:0] rot;
    } mover_cmd_t;

    typedef struct packed {
        logic [31:0] position;
        logic        motor_on;
        logic        motor_reverse;
        logic [7:0]  motor_speed;
        logic        move_done;
    } mover_out_t;

    // A result typed in by hand overrides the predicted one.
    typedef struct packed {
        logic       typed;
        mover_out_t want;
    } fixed_out_t;

    typedef struct packed {
        mover_cmd_t cmd;
        fixed_out_t fixed;
    } script_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [qpm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [qpm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [qpm_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic [2:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [qpm_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    quadrature_position_mover u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 12 unit period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predicted block state and register copies.
    logic [31:0] pos_count;
    logic        last_a;
    logic        last_b;
    logic        primed;
    logic [31:0] goal_pos;
    logic        moving;
    logic        drive_rev;
    logic [7:0]  drive_spd;
    logic [9:0]  gear_cfg;
    logic [11:0] cpr_cfg;
    logic [7:0]  home_cfg;

    mover_out_t  position_q[$];   // expected results in order
    fixed_out_t  typed_q[$];      // hand-typed results, one per offered item

    int mismatches;
    int items_in;
    int results_out;
    int moves_done;
    int settings_used;
    int quiet_cycles;
    int hold_left;
    bit hold_req;
    bit calm;

    // Encoder walker state, private to the stimulus.
    logic walk_a;
    logic walk_b;
    logic walk_up;
    int   aim_pos;

    // Stops a running move once the position reaches or passes its goal.
    function automatic logic settle_goal();
        logic hit;
        if (!moving)
            return 1'b0;
        hit = drive_rev ? ($signed(goal_pos) >= $signed(pos_count))
                        : ($signed(pos_count) >= $signed(goal_pos));
        if (hit) begin
            moving    = 1'b0;
            drive_rev = 1'b0;
            drive_spd = '0;
        end
        return hit;
    endfunction

    function automatic logic launch_move(logic [31:0] new_goal, logic rev, logic [7:0] spd);
        goal_pos  = new_goal;
        drive_rev = rev;
        drive_spd = spd;
        moving    = 1'b1;
        return settle_goal();
    endfunction

    // Advances the predicted state by one command and returns the result.
    function automatic mover_out_t track_mover(mover_cmd_t c);
        logic [37:0] prod;
        logic [31:0] delta;
        logic        done;
        mover_out_t  r;
        done = 1'b0;
        case (c.op)
            qpm_pkg::OP_SAMPLE: begin
                if (!primed) begin
                    last_a = c.enc_a;
                    last_b = c.enc_b;
                    primed = 1'b1;
                end else if (c.enc_a != last_a) begin
                    last_a    = c.enc_a;
                    pos_count = (c.enc_a != c.enc_b) ? pos_count + 1 : pos_count - 1;
                    done      = settle_goal();
                end else if (c.enc_b != last_b) begin
                    last_b    = c.enc_b;
                    pos_count = (c.enc_a == c.enc_b) ? pos_count + 1 : pos_count - 1;
                    done      = settle_goal();
                end
            end
            qpm_pkg::OP_GOTO: begin
                done = launch_move(c.target, c.rev, c.speed);
            end
            qpm_pkg::OP_MOVE_ROT: begin
                prod  = 38'(c.rot) * 38'(gear_cfg) * 38'(cpr_cfg);
                delta = 32'(prod >> 8);
                done  = launch_move(c.rev ? pos_count - delta : pos_count + delta,
                                    c.rev, c.speed);
            end
            qpm_pkg::OP_GO_HOME: begin
                done = launch_move('0, $signed(pos_count) > 0, home_cfg);
            end
            qpm_pkg::OP_RESET_HOME: begin
                pos_count = '0;
                done      = settle_goal();
            end
            default: begin
            end
        endcase
        r.position      = pos_count;
        r.motor_on      = moving;
        r.motor_reverse = moving & drive_rev;
        r.motor_speed   = moving ? drive_spd : 8'd0;
        r.move_done     = done;
        return r;
    endfunction

    function automatic mover_cmd_t make_cmd(logic [2:0] op, logic a, logic b, logic [7:0] spd,
                                            logic rev, logic [31:0] tgt, logic [15:0] rot);
        mover_cmd_t c;
        c.op     = op;
        c.enc_a  = a;
        c.enc_b  = b;
        c.speed  = spd;
        c.rev    = rev;
        c.target = tgt;
        c.rot    = rot;
        return c;
    endfunction

    function automatic fixed_out_t make_fixed(logic typed, logic [31:0] pos, logic on,
                                              logic rev, logic [7:0] spd, logic done);
        fixed_out_t f;
        f.typed              = typed;
        f.want.position      = pos;
        f.want.motor_on      = on;
        f.want.motor_reverse = rev;
        f.want.motor_speed   = spd;
        f.want.move_done     = done;
        return f;
    endfunction

    function automatic void note_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in result %0d, %s: expected %0h, got %0h",
                         results_out, field, want, got);
        end
    endfunction

    // Builds one random command; mostly clean encoder walks toward the running goal.
    function automatic mover_cmd_t pick_random_cmd();
        mover_cmd_t c;
        int         r;
        c.op     = qpm_pkg::OP_SAMPLE;
        c.enc_a  = walk_a;
        c.enc_b  = walk_b;
        c.speed  = 8'($urandom_range(255, 0));
        c.rev    = 1'($urandom_range(1, 0));
        c.target = $urandom;
        c.rot    = 16'($urandom);
        r = $urandom_range(99, 0);
        if (r < 66) begin
            if ($urandom_range(99, 0) < 6)
                walk_up = !walk_up;
            if ((walk_a == walk_b) == walk_up)
                walk_a = !walk_a;
            else
                walk_b = !walk_b;
            aim_pos = walk_up ? aim_pos + 1 : aim_pos - 1;
        end else if (r < 70) begin
            walk_a = 1'($urandom_range(1, 0));
            walk_b = 1'($urandom_range(1, 0));
        end else if (r < 73) begin
            // Both pins change in one sample.
            walk_a = !walk_a;
            walk_b = !walk_b;
        end else if (r < 81) begin
            c.op = qpm_pkg::OP_GOTO;
            if ($urandom_range(99, 0) >= 15) begin
                c.target = 32'(aim_pos + int'($urandom_range(80, 0)) - 40);
                if ($urandom_range(99, 0) < 85)
                    c.rev = $signed(c.target) < aim_pos;
            end
            walk_up = !c.rev;
        end else if (r < 88) begin
            c.op = qpm_pkg::OP_MOVE_ROT;
            if ($urandom_range(99, 0) >= 20)
                c.rot = 16'($urandom_range(255, 0));
            walk_up = !c.rev;
        end else if (r < 93) begin
            c.op    = qpm_pkg::OP_GO_HOME;
            walk_up = aim_pos < 0;
        end else if (r < 97) begin
            c.op    = qpm_pkg::OP_RESET_HOME;
            aim_pos = 0;
        end else begin
            c.op = 3'($urandom_range(OP_LAST_SPARE, OP_FIRST_SPARE));
        end
        if (c.op == qpm_pkg::OP_SAMPLE) begin
            c.enc_a = walk_a;
            c.enc_b = walk_b;
        end
        return c;
    endfunction

    // Output ready: random idling, a calm stretch, and one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99, 0) >= 30);
        end
    end

    // Checks each result transfer, then predicts each input transfer.
    always @(posedge aclk) begin : monitor
        mover_out_t got;
        mover_out_t want;
        mover_cmd_t cmd;
        fixed_out_t fx;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (m_axis_tvalid && m_axis_tready) begin
                got.position      = m_axis_tdata[31:0];
                got.motor_on      = m_axis_tdata[32];
                got.motor_reverse = m_axis_tdata[33];
                got.motor_speed   = m_axis_tdata[41:34];
                got.move_done     = m_axis_tdata[42];
                results_out++;
                if (got.move_done)
                    moves_done++;
                if (position_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d: position %0h", results_out,
                                 got.position);
                end else begin
                    want = position_q.pop_front();
                    note_field("position", want.position, got.position);
                    note_field("motor_on", 32'(want.motor_on), 32'(got.motor_on));
                    note_field("motor_reverse", 32'(want.motor_reverse),
                               32'(got.motor_reverse));
                    note_field("motor_speed", 32'(want.motor_speed), 32'(got.motor_speed));
                    note_field("move_done", 32'(want.move_done), 32'(got.move_done));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                cmd.op     = s_axis_tuser;
                cmd.enc_a  = s_axis_tdata[0];
                cmd.enc_b  = s_axis_tdata[1];
                cmd.speed  = s_axis_tdata[9:2];
                cmd.rev    = s_axis_tdata[10];
                cmd.target = s_axis_tdata[42:11];
                cmd.rot    = s_axis_tdata[58:43];
                fx.typed   = 1'b0;
                fx.want    = '0;
                if (typed_q.size() != 0)
                    fx = typed_q.pop_front();
                want = track_mover(cmd);
                position_q.push_back(fx.typed ? fx.want : want);
                items_in++;
            end
        end
    end

    // Offers one command and returns at the edge of its transfer, maybe after a gap.
    task automatic offer(mover_cmd_t c, fixed_out_t f);
        typed_q.push_back(f);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {5'b0, c.rot, c.target, c.rev, c.speed, c.enc_b, c.enc_a};
        @(posedge aclk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge aclk);
        if (!calm && $urandom_range(99, 0) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Waits for every pending result, then lets the block settle.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (position_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(qpm_pkg::cfg_idx_t idx, logic [qpm_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            qpm_pkg::CFG_GEAR_RATIO:     gear_cfg = value[9:0];
            qpm_pkg::CFG_COUNTS_PER_REV: cpr_cfg  = value;
            qpm_pkg::CFG_HOME_SPEED:     home_cfg = value[7:0];
            default: begin
            end
        endcase
    endtask

    // Gives up when nothing has moved on either side for too long.
    initial begin : watchdog
        quiet_cycles = 0;
        @(posedge aclk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("no transfer for %0d cycles, %0d results still pending", QUIET_LIMIT,
                 position_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        script_row_t                    script [SCRIPT_ROWS];
        fixed_out_t                     plain;
        logic [qpm_pkg::CFG_DATA_W-1:0] g;
        logic [qpm_pkg::CFG_DATA_W-1:0] k;
        logic [qpm_pkg::CFG_DATA_W-1:0] h;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = qpm_pkg::CFG_GEAR_RATIO;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = qpm_pkg::OP_SAMPLE;
        m_axis_tready = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        calm          = 1'b0;
        mismatches    = 0;
        items_in      = 0;
        results_out   = 0;
        moves_done    = 0;
        settings_used = 1;
        walk_a        = 1'b0;
        walk_b        = 1'b0;
        walk_up       = 1'b1;
        aim_pos       = 0;

        // Predictor state after reset.
        pos_count = '0;
        last_a    = 1'b0;
        last_b    = 1'b0;
        primed    = 1'b0;
        goal_pos  = '0;
        moving    = 1'b0;
        drive_rev = 1'b0;
        drive_spd = '0;
        gear_cfg  = qpm_pkg::GEAR_RATIO_RST;
        cpr_cfg   = qpm_pkg::COUNTS_PER_REV_RST;
        home_cfg  = qpm_pkg::HOME_SPEED_RST;

        plain = make_fixed(1'b0, '0, 1'b0, 1'b0, '0, 1'b0);

        // Directed table at the reset register values; typed results only where obvious.
        // First sample only primes; then single steps up and a sample where both pins move.
        script[0]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0),
                       make_fixed(1'b1, 32'd0, 1'b0, 1'b0, 8'd0, 1'b0)};
        script[1]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 0, 0, 0, 0, 0),
                       make_fixed(1'b1, 32'd1, 1'b0, 1'b0, 8'd0, 1'b0)};
        script[2]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 1, 0, 0, 0, 0),
                       make_fixed(1'b1, 32'd2, 1'b0, 1'b0, 8'd0, 1'b0)};
        script[3]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 1, 0, 0, 0, 0), plain};
        script[4]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0), plain};
        script[5]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 1, 0, 0, 0, 0), plain};
        script[6]  = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 1, 0, 0, 0, 0), plain};
        // Extreme targets: one far ahead, one already passed.
        script[7]  = '{make_cmd(qpm_pkg::OP_GOTO, 0, 0, 8'd255, 0, 32'h7FFF_FFFF, 0),
                       make_fixed(1'b1, 32'd4, 1'b1, 1'b0, 8'd255, 1'b0)};
        script[8]  = '{make_cmd(qpm_pkg::OP_GOTO, 0, 0, 8'd0, 0, 32'h8000_0000, 0),
                       make_fixed(1'b1, 32'd4, 1'b0, 1'b0, 8'd0, 1'b1)};
        script[9]  = '{make_cmd(qpm_pkg::OP_GOTO, 0, 0, 8'd200, 1, 32'h8000_0000, 0), plain};
        script[10] = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 1, 0, 0, 0, 0), plain};
        // Reset home during a move, then a new move replacing the running one.
        script[11] = '{make_cmd(qpm_pkg::OP_RESET_HOME, 0, 0, 0, 0, 0, 0), plain};
        script[12] = '{make_cmd(qpm_pkg::OP_GOTO, 0, 0, 8'd17, 0, 32'd2, 0), plain};
        script[13] = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0), plain};
        script[14] = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 0, 0, 0, 0, 0), plain};
        // Largest and zero rotation operands.
        script[15] = '{make_cmd(qpm_pkg::OP_MOVE_ROT, 0, 0, 8'd9, 0, 0, 16'hFFFF), plain};
        script[16] = '{make_cmd(qpm_pkg::OP_MOVE_ROT, 0, 0, 8'd3, 1, 0, 16'h0000), plain};
        // Go home from above zero, at zero and from below zero.
        script[17] = '{make_cmd(qpm_pkg::OP_GO_HOME, 0, 0, 0, 0, 0, 0), plain};
        script[18] = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0), plain};
        script[19] = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 1, 0, 0, 0, 0), plain};
        script[20] = '{make_cmd(qpm_pkg::OP_GO_HOME, 0, 0, 0, 0, 0, 0), plain};
        script[21] = '{make_cmd(qpm_pkg::OP_SAMPLE, 1, 1, 0, 0, 0, 0), plain};
        script[22] = '{make_cmd(qpm_pkg::OP_GO_HOME, 0, 0, 0, 0, 0, 0), plain};
        script[23] = '{make_cmd(qpm_pkg::OP_SAMPLE, 0, 1, 0, 0, 0, 0), plain};
        // Unused operation codes leave everything as it was.
        script[24] = '{make_cmd(OP_FIRST_SPARE, 1, 1, 8'hFF, 1, 32'hFFFF_FFFF, 16'hFFFF),
                       plain};
        script[25] = '{make_cmd(OP_LAST_SPARE, 0, 0, 0, 0, 0, 0), plain};
        script[26] = '{make_cmd(qpm_pkg::OP_RESET_HOME, 0, 0, 0, 0, 0, 0), plain};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            offer(script[i].cmd, script[i].fixed);
        drain_results();

        // Random walks and commands under several register settings.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    g = 12'd1023;
                    k = 12'd4095;
                    h = 12'd255;
                end
                1: begin
                    g = 12'd1;
                    k = 12'd1;
                    h = 12'd0;
                end
                2: begin
                    g = 12'(qpm_pkg::GEAR_RATIO_RST);
                    k = qpm_pkg::COUNTS_PER_REV_RST;
                    h = 12'(qpm_pkg::HOME_SPEED_RST);
                end
                3: begin
                    // A zero gear ratio makes every rotation move zero long.
                    g = 12'd0;
                    k = 12'($urandom_range(4095, 1));
                    h = 12'($urandom_range(255, 0));
                end
                default: begin
                    g = 12'($urandom_range(1023, 1));
                    k = 12'($urandom_range(64, 1));
                    h = 12'($urandom_range(255, 0));
                end
            endcase
            set_register(qpm_pkg::CFG_GEAR_RATIO, g);
            set_register(qpm_pkg::CFG_COUNTS_PER_REV, k);
            set_register(qpm_pkg::CFG_HOME_SPEED, h);
            settings_used++;

            // One long output stall while inputs keep coming; one phase with no idling.
            if (ph == 0)
                hold_req = 1'b1;
            calm = (ph == 2);
            for (int n = 0; n < RANDOM_ITEMS; n++)
                offer(pick_random_cmd(), plain);
            drain_results();
        end
        calm = 1'b0;

        $display("Covered %0d input transfers and %0d results over %0d register settings,",
                 items_in, results_out, settings_used);
        $display("with %0d finished moves and a %0d-cycle output stall.", moves_done,
                 HOLD_CYCLES);
        if (position_q.size() != 0)
            $display("%0d expected results never arrived", position_q.size());
        if (mismatches == 0 && position_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/qpm_pkg.sv
design/qpm_ctrl.sv
design/qpm_datapath.sv
design/quadrature_position_mover.sv
tb/sv/quadrature_position_mover_tb.sv
